FILE: rtl/mass_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mass_pkg
// shared constants and types of the multi-axis safety supervisor
// ----------------------------------------------------------------------------
package mass_pkg;

   localparam int AxisCountDefault = 8;
   localparam int AxisIndexMax     = 16;

   // request commands
   localparam logic [1:0] CMD_REPORT_STATUS = 2'd0;
   localparam logic [1:0] CMD_REPORT_EMERG  = 2'd1;
   localparam logic [1:0] CMD_SET_ESTOP     = 2'd2;
   localparam logic [1:0] CMD_EVALUATE      = 2'd3;

   // system states
   localparam logic [2:0] ST_INIT    = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_ENABLED = 3'd2;
   localparam logic [2:0] ST_RUNNING = 3'd3;
   localparam logic [2:0] ST_FAULT   = 3'd4;
   localparam logic [2:0] ST_ESTOP   = 3'd5;

   // drive status / control words
   localparam logic [15:0] SW_FAULT        = 16'h0008;
   localparam logic [15:0] SW_OPEN_VALUE   = 16'h0027;
   localparam logic [15:0] SW_OPEN_MASK    = 16'h006F;
   localparam logic [15:0] QUICK_STOP_CW   = 16'h0002;
   localparam logic [15:0] CW_DISABLE_VOLT = 16'h0000;

   // register indexes
   localparam logic REG_COMMS_TIMEOUT = 1'b0;
   localparam logic REG_REQUIRE_ALL   = 1'b1;

   localparam logic [31:0] COMMS_TIMEOUT_RESET = 32'd100;
   localparam logic        REQUIRE_ALL_RESET   = 1'b1;

   // scan verdict handed back to the top level
   typedef struct packed {
      logic       done;
      logic [2:0] state;
   } scan_result_type;

endpackage

FILE: rtl/mass_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mass_scan
// axis scan sequencer: one axis per cycle through a shared age/status check
// ----------------------------------------------------------------------------
module mass_scan #(
   parameter int AXIS_COUNT = mass_pkg::AxisCountDefault,
   parameter int IDX_W      = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [31:0]               now,
   input  logic [31:0]               timeout,
   input  logic                      require_all,
   output logic [IDX_W-1:0]          rd_index,
   input  logic [15:0]               rd_status,
   input  logic [31:0]               rd_time,
   input  logic                      rd_emergency,
   output mass_pkg::scan_result_type result
);
   import mass_pkg::*;

   localparam logic [IDX_W-1:0] LastIdx = IDX_W'(AXIS_COUNT - 1);

   logic             active_ff, active_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      now_ff, now_in;
   logic             fault_ff, fault_in;
   logic             all_ff, all_in;
   logic             any_ff, any_in;

   logic [31:0] age;
   logic        stale;
   logic        axis_fault;
   logic        axis_on;
   logic        fault_t, all_t, any_t;
   logic        last;

   // shared unit: wraparound age and compare, status decode
   assign age        = now_ff - rd_time;
   assign stale      = (rd_time != 32'd0) && (age > timeout);
   assign axis_fault = ((rd_status & SW_FAULT) != 16'd0) || rd_emergency || stale;
   assign axis_on    = (rd_status & SW_OPEN_MASK) == SW_OPEN_VALUE;

   assign fault_t = fault_ff | axis_fault;
   assign all_t   = all_ff & axis_on;
   assign any_t   = any_ff | axis_on;
   assign last    = active_ff && (idx_ff == LastIdx);

   assign rd_index = idx_ff;

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      now_in    = now_ff;
      fault_in  = fault_ff;
      all_in    = all_ff;
      any_in    = any_ff;
      if (start) begin
         active_in = 1'b1;
         idx_in    = '0;
         now_in    = now;
         fault_in  = 1'b0;
         all_in    = 1'b1;
         any_in    = 1'b0;
      end else if (active_ff) begin
         fault_in = fault_t;
         all_in   = all_t;
         any_in   = any_t;
         if (last) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      result.done = last;
      if (fault_t) begin
         result.state = ST_FAULT;
      end else if (require_all ? all_t : any_t) begin
         result.state = ST_RUNNING;
      end else begin
         result.state = ST_ENABLED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
      now_ff   <= now_in;
      fault_ff <= fault_in;
      all_ff   <= all_in;
      any_ff   <= any_in;
   end

endmodule

FILE: rtl/multi_axis_safety_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_axis_safety_supervisor
// per-axis status/time/emergency store with a sequenced safety evaluation
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Report status,
// report emergency and set estop requests need no scan: the result
// strobe rsp_valid comes on the next cycle and busy stays low, so such
// requests may follow each other every cycle. An evaluate request scans one
// axis per cycle through a single shared age-compare and status-decode unit,
// so busy stays high while all AXIS_COUNT axes are scanned and the result is
// registered from the check of the last axis; with the emergency stop
// latched the scan is skipped and the result comes on the next cycle. Every
// request gives exactly one result, shown for one cycle only: the receiver
// cannot stall it and must take it when rsp_valid is high.
// Registers: comms_timeout at byte 0x0, require_all_enabled at byte 0x4;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module multi_axis_safety_supervisor #(
   parameter int AXIS_COUNT = mass_pkg::AxisCountDefault
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_axis_index,
   input  logic [15:0] req_status_word,
   input  logic [31:0] req_time_ms,
   input  logic        req_active_flag,
   // result channel
   output logic        rsp_valid,
   output logic [2:0]  rsp_system_state,
   output logic        rsp_no_danger,
   output logic [15:0] rsp_safe_control_word,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mass_pkg::*;

   localparam int IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

   // configuration registers
   logic [31:0] timeout_ff;
   logic        req_all_ff;

   // per-axis store, cleared by reset
   logic [15:0] status_ff [AXIS_COUNT];
   logic [31:0] time_ff   [AXIS_COUNT];
   logic        emerg_ff  [AXIS_COUNT];

   // control state
   logic       estop_ff;
   logic [2:0] state_ff, state_in;
   logic       busy_ff, busy_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             axis_ok;
   logic [IDX_W-1:0] wr_idx;
   logic             scan_start;
   logic             cfg_write;
   logic [IDX_W-1:0] rd_index;
   scan_result_type  scan_res;

   // request handshake
   assign accept  = start && !busy_ff;
   assign busy    = busy_ff;
   // out-of-range axis indexes are dropped
   assign axis_ok = {1'b0, req_axis_index} < 5'(AXIS_COUNT);
   assign wr_idx  = req_axis_index[IDX_W-1:0];

   // evaluate with estop latched skips the scan
   assign scan_start = accept && (req_command == CMD_EVALUATE) && !estop_ff;

   // register port, no wait states
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         REG_COMMS_TIMEOUT: csr_prdata = timeout_ff;
         REG_REQUIRE_ALL:   csr_prdata = {31'd0, req_all_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= COMMS_TIMEOUT_RESET;
         req_all_ff <= REQUIRE_ALL_RESET;
      end else if (cfg_write) begin
         case (csr_paddr[2])
            REG_COMMS_TIMEOUT: timeout_ff <= csr_pwdata;
            REG_REQUIRE_ALL:   req_all_ff <= csr_pwdata[0];
            default:           ;
         endcase
      end
   end

   // axis store updates and estop latch
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXIS_COUNT; a++) begin
            status_ff[a] <= 16'd0;
            time_ff[a]   <= 32'd0;
            emerg_ff[a]  <= 1'b0;
         end
         estop_ff <= 1'b0;
      end else if (accept) begin
         case (req_command)
            CMD_REPORT_STATUS: begin
               if (axis_ok) begin
                  status_ff[wr_idx] <= req_status_word;
                  time_ff[wr_idx]   <= req_time_ms;
               end
            end
            CMD_REPORT_EMERG: begin
               if (axis_ok) begin
                  emerg_ff[wr_idx] <= req_active_flag;
               end
            end
            CMD_SET_ESTOP: estop_ff <= req_active_flag;
            default:       ;
         endcase
      end
   end

   // shared scan unit
   mass_scan #(
      .AXIS_COUNT (AXIS_COUNT),
      .IDX_W      (IDX_W)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_start),
      .now          (req_time_ms),
      .timeout      (timeout_ff),
      .require_all  (req_all_ff),
      .rd_index     (rd_index),
      .rd_status    (status_ff[rd_index]),
      .rd_time      (time_ff[rd_index]),
      .rd_emergency (emerg_ff[rd_index]),
      .result       (scan_res)
   );

   // sequencer: commands without a scan, estop shortcut, scan completion
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      if (busy_ff) begin
         if (scan_res.done) begin
            state_in     = scan_res.state;
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
      end else if (accept) begin
         if (scan_start) begin
            busy_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
            if (req_command == CMD_EVALUATE) begin
               state_in = ST_ESTOP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result fields follow the held state
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_system_state      = state_ff;
   assign rsp_no_danger         = (state_ff == ST_ENABLED) || (state_ff == ST_RUNNING);
   assign rsp_safe_control_word = (state_ff == ST_ESTOP) ? CW_DISABLE_VOLT : QUICK_STOP_CW;

endmodule
